// File: hw/rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
`default_nettype none

package deq_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    // Command codes; codes above CMD_LIST are ignored
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_LIST       = 3'd4
    } t_cmd;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    // Controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_LIST = 1'b1
    } t_state;

endpackage

`default_nettype wire

// File: hw/rtl/deq_if.sv
// Valid/ready channel interfaces for queue commands and results.
`default_nettype none

interface deq_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [deq_pkg::CMD_W-1:0]         command;
    logic signed [deq_pkg::DATA_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface deq_res_if;
    logic                              valid;
    logic                              ready;
    logic signed [deq_pkg::DATA_W-1:0] data;
    logic [deq_pkg::STAT_W-1:0]        status;
    logic                              last;

    modport source (output valid, output data, output status, output last, input ready);
    modport sink   (input valid, input data, input status, input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; hold data while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: hw/rtl/double_ended_queue.sv
// Top level of the bounded double-ended queue with RAM-backed entry ring.
`default_nettype none

// A bounded double-ended queue of signed 32-bit values held in a ring of DEPTH words in one
// synchronous RAM. Push front, push back, pop front, pop back and any unused command code
// each complete in the cycle they are accepted, and their result is valid the next cycle, so
// these transactions can follow one another every cycle while results are taken. Each push
// and each pop yields exactly one result, and unused codes yield none. A list of N entries
// reads the RAM once per entry through its single read port: each read word is held as
// pending list data and then moved into the result register, and the entries follow at one
// per cycle while results are taken; no new command is taken until the last entry has
// left the pending slot. An empty list, a pop from an empty queue and a push into a full
// queue give one result with the empty or full status. A single result register holds
// the outgoing result; a new command is taken only when that register is empty or its
// result is taken in the same cycle, so backpressure on the result channel stalls commands.
module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    deq_cmd_if.sink   i_cmd,
    deq_res_if.source o_res
);

    import deq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;

    // Ring position helpers
    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        logic [AW-1:0] q;
        if (p == AW'(DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] p);
        logic [AW-1:0] q;
        if (p == '0) begin
            q = AW'(DEPTH - 1);
        end else begin
            q = p - 1'b1;
        end
        return q;
    endfunction

    t_state              r_state, n_state;
    logic [AW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]       r_left, n_left;
    logic                r_rd_pend, n_rd_pend;
    logic                r_rd_last, n_rd_last;
    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_out_data, n_out_data;
    logic [STAT_W-1:0]   r_out_status, n_out_status;
    logic                r_out_last, n_out_last;

    logic                in_ready;
    logic                in_acc;
    logic                out_free;
    logic                full;
    logic                empty;
    logic [SW-1:0]       tail_sum;
    logic [AW-1:0]       tail_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic                rd_en;
    logic [DATA_W-1:0]   rd_data;

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_cmd.value),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (rd_data)
    );

    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign out_free  = !r_out_valid || o_res.ready;
    assign tail_sum  = SW'(r_head) + SW'(r_count);
    assign tail_addr = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
    assign in_ready  = (r_state == S_IDLE) && !r_rd_pend && out_free;
    assign in_acc    = in_ready && i_cmd.valid;

    // Next state, queue pointers, list reads and result register
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_rd_ptr     = r_rd_ptr;
        n_left       = r_left;
        n_rd_pend    = r_rd_pend;
        n_rd_last    = r_rd_last;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        wr_en        = 1'b0;
        wr_addr      = tail_addr;
        rd_en        = 1'b0;

        // Drop the taken result
        if (out_free) begin
            n_out_valid = 1'b0;
        end

        // Advance pending list data into the result register
        if (r_rd_pend && out_free) begin
            n_out_valid  = 1'b1;
            n_out_data   = rd_data;
            n_out_status = STAT_OK;
            n_out_last   = r_rd_last;
            n_rd_pend    = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_out_data   = '0;
                    n_out_last   = 1'b1;
                    n_out_status = STAT_OK;
                    n_out_valid  = 1'b1;
                    case (t_cmd'(i_cmd.command))
                        CMD_PUSH_FRONT: begin
                            if (full) begin
                                n_out_status = STAT_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = f_dec(r_head);
                                n_head  = f_dec(r_head);
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_PUSH_BACK: begin
                            if (full) begin
                                n_out_status = STAT_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = tail_addr;
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (empty) begin
                                n_out_status = STAT_EMPTY;
                            end else begin
                                n_head  = f_inc(r_head);
                                n_count = r_count - 1'b1;
                            end
                        end
                        CMD_POP_BACK: begin
                            if (empty) begin
                                n_out_status = STAT_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        CMD_LIST: begin
                            if (empty) begin
                                n_out_status = STAT_EMPTY;
                            end else begin
                                n_out_valid = 1'b0;
                                n_state     = S_LIST;
                                n_rd_ptr    = r_head;
                                n_left      = r_count;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b0;
                        end
                    endcase
                end
            end
            S_LIST: begin
                // Issue the next read once the read data slot will be free
                if (!r_rd_pend || out_free) begin
                    rd_en     = 1'b1;
                    n_rd_pend = 1'b1;
                    n_rd_last = (r_left == CW'(1));
                    n_rd_ptr  = f_inc(r_rd_ptr);
                    n_left    = r_left - 1'b1;
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_left      <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_left      <= n_left;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_ptr     <= n_rd_ptr;
        r_rd_last    <= n_rd_last;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign i_cmd.ready  = in_ready;
    assign o_res.valid  = r_out_valid;
    assign o_res.data   = r_out_data;
    assign o_res.status = r_out_status;
    assign o_res.last   = r_out_last;

    // A push into a full queue reports the full status next cycle
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && full && (i_cmd.command == CMD_PUSH_FRONT || i_cmd.command == CMD_PUSH_BACK))
        |=> (r_out_valid && r_out_status == STAT_FULL && r_out_last))
        else $error("full push did not report full status");

    // A list in progress always has reads left to issue
    a_list_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> (r_left != '0))
        else $error("list state with no entries left");

    // No RAM write while list reads are outstanding
    a_no_write_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST || r_rd_pend) |-> !wr_en)
        else $error("RAM write during list");

    // Pending list data is held until the result register takes it
    a_pend_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_pend && !out_free) |=> (r_rd_pend && $stable(r_rd_last) && $stable(rd_data)))
        else $error("pending list data lost");

    // The entry count never exceeds the ring size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_count <= CW'(DEPTH)))
        else $error("entry count out of range");

endmodule

`default_nettype wire

// File: tb/double_ended_queue_tb.sv
// Self-checking testbench for the double-ended queue: random commands, shadow deque, result check.
`default_nettype none

module double_ended_queue_tb;
    import deq_pkg::*;

    localparam int DEPTH          = 16;
    localparam int CLK_PERIOD     = 10;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int RANDOM_ITEMS   = 350;
    localparam int IDLE_PCT       = 23;
    localparam int HOLD_AT        = 120;
    localparam int HOLD_CYCLES    = 80;
    localparam int STEADY_FROM    = 200;
    localparam int STEADY_TO      = 260;
    localparam int TAIL_CYCLES    = 20;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    // Codes above CMD_LIST that the block drops
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]         command;
        logic signed [DATA_W-1:0] value;
        bit                       drain_first;
    } t_deq_request;

    typedef struct {
        logic signed [DATA_W-1:0] data;
        t_status                  status;
        logic                     last;
    } t_deq_result;

    logic clk;
    logic rst_n;

    deq_cmd_if cmd_ch ();
    deq_res_if res_ch ();

    double_ended_queue #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_cmd  (cmd_ch.sink),
        .o_res  (res_ch.source)
    );

    t_deq_request request_queue[$];
    t_deq_result  expected_results[$];

    // Shadow copy of the deque contents
    logic signed [DATA_W-1:0] shadow_ring [DEPTH];
    int shadow_head;
    int shadow_count;

    int  cmd_count;
    int  n_errors;
    logic cmd_taken;
    int  hold_left;
    bit  hold_done;

    // Clock
    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Timeout
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("double_ended_queue_tb NOT OK");
        $finish;
    end

    // No idling on either side inside this window of transactions
    function automatic bit in_steady_window();
        return cmd_count >= STEADY_FROM && cmd_count < STEADY_TO;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_request(input logic [CMD_W-1:0] command,
                               input logic signed [DATA_W-1:0] value,
                               input bit drain_first = 1'b0);
        t_deq_request req;
        req.command     = command;
        req.value       = value;
        req.drain_first = drain_first;
        request_queue.push_back(req);
    endtask

    task automatic expect_result(input logic signed [DATA_W-1:0] data,
                                 input t_status status, input logic last);
        t_deq_result r;
        r.data   = data;
        r.status = status;
        r.last   = last;
        expected_results.push_back(r);
    endtask

    // Apply one accepted command to the shadow deque and queue its results
    task automatic deque_apply(input logic [CMD_W-1:0] command,
                               input logic signed [DATA_W-1:0] value);
        case (command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (shadow_count >= DEPTH) begin
                    expect_result('0, STAT_FULL, 1'b1);
                end else begin
                    if (command == CMD_PUSH_FRONT) begin
                        shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                        shadow_ring[shadow_head] = value;
                    end else begin
                        shadow_ring[(shadow_head + shadow_count) % DEPTH] = value;
                    end
                    shadow_count++;
                    expect_result('0, STAT_OK, 1'b1);
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (shadow_count == 0) begin
                    expect_result('0, STAT_EMPTY, 1'b1);
                end else begin
                    if (command == CMD_POP_FRONT)
                        shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_count--;
                    expect_result('0, STAT_OK, 1'b1);
                end
            end
            CMD_LIST: begin
                if (shadow_count == 0) begin
                    expect_result('0, STAT_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < shadow_count; i++)
                        expect_result(shadow_ring[(shadow_head + i) % DEPTH], STAT_OK,
                                      i == shadow_count - 1);
                end
            end
            default: ;
        endcase
    endtask

    // Monitor: check results and predict on every accepted command
    always @(posedge clk) begin : monitor
        t_deq_result want;
        if (!rst_n) begin
            cmd_taken <= 1'b0;
        end else begin
            cmd_taken <= cmd_ch.valid && cmd_ch.ready;
            if (res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result data=%0d status=%0d last=%0d",
                             $time, res_ch.data, res_ch.status, res_ch.last);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (res_ch.data !== want.data) begin
                        $display("%0t: data mismatch expected=%0d actual=%0d",
                                 $time, want.data, res_ch.data);
                        n_errors++;
                    end
                    if (res_ch.status !== want.status) begin
                        $display("%0t: status mismatch expected=%0d actual=%0d",
                                 $time, want.status, res_ch.status);
                        n_errors++;
                    end
                    if (res_ch.last !== want.last) begin
                        $display("%0t: last mismatch expected=%0d actual=%0d",
                                 $time, want.last, res_ch.last);
                        n_errors++;
                    end
                end
            end
            if (cmd_ch.valid && cmd_ch.ready) begin
                deque_apply(cmd_ch.command, cmd_ch.value);
                cmd_count <= cmd_count + 1;
            end
        end
    end

    // Driver: hold the current transaction until taken, then offer the next one
    always @(negedge clk) begin : driver
        t_deq_request req;
        if (rst_n && (!cmd_ch.valid || cmd_taken)) begin
            if (request_queue.size() != 0
                    && !(request_queue[0].drain_first && expected_results.size() != 0)
                    && (in_steady_window() || $urandom_range(99) >= IDLE_PCT)) begin
                req = request_queue.pop_front();
                cmd_ch.valid   <= 1'b1;
                cmd_ch.command <= req.command;
                cmd_ch.value   <= req.value;
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off to back up the block
    always @(negedge clk) begin
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            res_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (!hold_done && cmd_count >= HOLD_AT) begin
            res_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES - 1;
            hold_done    <= 1'b1;
        end else begin
            res_ch.ready <= in_steady_window() || $urandom_range(99) >= IDLE_PCT;
        end
    end

    // Reset, stimulus and end of run
    initial begin
        int n;
        int phase_kind;
        int phase_len;
        int push_pct;
        int roll;
        logic [CMD_W-1:0] command;

        cmd_ch.valid   = 1'b0;
        cmd_ch.command = '0;
        cmd_ch.value   = '0;
        res_ch.ready   = 1'b0;
        rst_n          = 1'b0;
        shadow_head    = 0;
        shadow_count   = 0;
        cmd_count      = 0;
        n_errors       = 0;
        cmd_taken      = 1'b0;
        hold_left      = 0;
        hold_done      = 1'b0;
        foreach (shadow_ring[i]) shadow_ring[i] = '0;

        // Directed: empty queue cases
        add_request(CMD_LIST, '0);
        add_request(CMD_POP_FRONT, '0);
        add_request(CMD_POP_BACK, VAL_MAX);
        // Pop of the only entry from either end
        add_request(CMD_PUSH_BACK, VAL_MAX);
        add_request(CMD_POP_FRONT, '0);
        add_request(CMD_PUSH_FRONT, VAL_MIN);
        add_request(CMD_POP_BACK, '0);
        // Ignored codes
        for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++)
            add_request(CMD_W'(c), pick_value());
        // Fill from both ends, overflow at both ends, list the full ring
        for (int i = 0; i < DEPTH; i++)
            add_request(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
                        (i < 4) ? ((i < 2) ? VAL_MIN : VAL_MAX) : pick_value());
        add_request(CMD_PUSH_FRONT, -1);
        add_request(CMD_PUSH_BACK, -1);
        add_request(CMD_LIST, '0);

        // Random: phases biased toward filling, draining or a mix
        n = 0;
        while (n < RANDOM_ITEMS) begin
            phase_kind = $urandom_range(2);
            phase_len  = $urandom_range(8, 30);
            push_pct   = (phase_kind == 0) ? 75 : (phase_kind == 1) ? 15 : 45;
            repeat (phase_len) begin
                roll = $urandom_range(99);
                if (roll < 4)
                    command = CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
                else if (roll < 14)
                    command = CMD_LIST;
                else if ($urandom_range(99) < push_pct)
                    command = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
                else
                    command = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
                // Let the block drain completely at the start and midway
                add_request(command, pick_value(), n == 0 || n == RANDOM_ITEMS / 2);
                if (command <= CMD_LIST)
                    n++;
            end
        end

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every transaction to go out and every result to come back
        while (request_queue.size() != 0 || cmd_ch.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("double_ended_queue_tb OK");
        end else begin
            $display("double_ended_queue_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
